// File: rtl/core/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// Shared types, codes and constants of the pose history interpolator.
// ----------------------------------------------------------------------------
package php_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] MODE_EMPTY  = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_BRACK  = 2'd2;
    localparam logic [1:0] MODE_EXTRAP = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN     = 1'd1;
    localparam logic [19:0] EXTRAP_LIMIT_RESET = 20'd60000;
    localparam logic [9:0]  MIN_SPAN_RESET     = 10'd1;

    // Q16.16 half and full turn
    localparam logic signed [34:0] HALF_TURN = 35'sd11796480;
    localparam logic signed [34:0] FULL_TURN = 35'sd23592960;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] WRAP_LAST = 6'd7;
    localparam logic [STEP_W-1:0] MUL_LAST  = 6'd31;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [31:0] yaw;
        logic signed [31:0] pitch;
    } pose_t;

    localparam int POSE_W = $bits(pose_t);

    typedef struct packed {
        logic              push;
        logic              clear;
        logic              load_q;
        logic              scan_clr;
        logic              scan_inc;
        logic              rd;
        logic              capture;
        logic              setup;
        logic              wrap_step;
        logic              mul_step;
        logic              div_step;
        logic              finish;
        logic [1:0]        mode;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic first;
        logic last;
        logic hit;
        logic hold;
    } stat_t;

endpackage

// File: rtl/core/php_if.sv
// ----------------------------------------------------------------------------
// php_in_if / php_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface php_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [31:0]        sample_time;
    logic signed [31:0] yaw_in;
    logic signed [31:0] pitch_in;

    modport source (output valid, op, sample_time, yaw_in, pitch_in, input ready);
    modport sink   (input valid, op, sample_time, yaw_in, pitch_in, output ready);
endinterface

interface php_out_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [31:0] yaw_out;
    logic signed [31:0] pitch_out;

    modport source (output valid, valid_res, yaw_out, pitch_out, input ready);
    modport sink   (input valid, valid_res, yaw_out, pitch_out, output ready);
endinterface

// File: rtl/core/php_ram.sv
// ----------------------------------------------------------------------------
// php_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module php_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/php_ctrl.sv
// ----------------------------------------------------------------------------
// php_ctrl
// Sequencer: handshakes, ring scan, yaw wrap, multiply and divide steps.
// ----------------------------------------------------------------------------
module php_ctrl import php_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CAPT  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_WRAP  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mode       = mode_reg;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (in_op == OP_PUSH)
                    begin
                        cmd.push = 1'b1;
                    end
                    else if (in_op == OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (in_op == OP_QUERY)
                    begin
                        cmd.load_q   = 1'b1;
                        cmd.scan_clr = 1'b1;
                        if (stat.count_zero)
                        begin
                            mode_next  = MODE_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        // unused code: drop
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                cmd.capture = 1'b1;
                priority if (stat.first && (stat.count_one || stat.hit))
                begin
                    mode_next  = MODE_FIRST;
                    state_next = S_FIN;
                end
                else if (!stat.first && stat.hit)
                begin
                    mode_next  = MODE_BRACK;
                    state_next = S_SETUP;
                end
                else if (!stat.first && stat.last)
                begin
                    mode_next  = MODE_EXTRAP;
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == WRAP_LAST)
                begin
                    step_next  = '0;
                    state_next = stat.hold ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_EMPTY;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/php_dp.sv
// ----------------------------------------------------------------------------
// php_dp
// Datapath: sample ring, scan registers, yaw wrap, shift-add multiply,
// restoring divide and saturating output register.
// ----------------------------------------------------------------------------
module php_dp import php_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [31:0]           sample_time,
    input  logic signed [31:0]    yaw_in,
    input  logic signed [31:0]    pitch_in,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  valid_res,
    output logic signed [31:0]    yaw_out,
    output logic signed [31:0]    pitch_out
);

    logic [19:0]       limit_reg;
    logic [9:0]        min_span_reg;
    logic [ADDR_W-1:0] oldest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] idx_reg;

    pose_t             a_reg, b_reg, rdata;
    logic [31:0]       tq_reg;
    logic signed [34:0] dy_reg;
    logic signed [32:0] dp_reg;
    logic              wrap_pos_reg, wrap_neg_reg, hold_reg;
    logic [31:0]       n_reg, den_reg;
    logic [63:0]       prod_y_reg, prod_p_reg;
    logic [31:0]       rem_y_reg, rem_p_reg;

    // ring
    pose_t wdata;
    assign wdata = '{t: sample_time, yaw: yaw_in, pitch: pitch_in};

    php_ram #(.WIDTH(POSE_W), .DEPTH(HISTORY_DEPTH)) u_ring (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (oldest_reg + count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (oldest_reg + idx_reg),
        .rdata (rdata)
    );

    assign stat.count_zero = (count_reg == '0);
    assign stat.count_one  = (count_reg == CNT_W'(1));
    assign stat.first      = (idx_reg == '0);
    assign stat.last       = ({1'b0, idx_reg} == CNT_W'(count_reg - 1'b1));
    assign stat.hit        = (tq_reg <= rdata.t);
    assign stat.hold       = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= EXTRAP_LIMIT_RESET;
            min_span_reg <= MIN_SPAN_RESET;
            oldest_reg   <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EXTRAP_LIMIT: limit_reg    <= cfg_data;
                    CFG_MIN_SPAN:     min_span_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (cmd.push)
            begin
                if (count_reg == CNT_W'(HISTORY_DEPTH))
                begin
                    oldest_reg <= oldest_reg + 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.clear)
            begin
                oldest_reg <= '0;
                count_reg  <= '0;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // setup terms from the bracketing pair
    logic signed [32:0] span, num_b, dt, dt_c;
    logic signed [34:0] dy_raw;
    logic               span_bad, hold_b, hold_e;

    always_comb
    begin
        span     = $signed({1'b0, b_reg.t}) - $signed({1'b0, a_reg.t});
        num_b    = $signed({1'b0, tq_reg}) - $signed({1'b0, a_reg.t});
        dt       = $signed({1'b0, tq_reg}) - $signed({1'b0, b_reg.t});
        dt_c     = (dt > $signed({13'd0, limit_reg})) ? $signed({13'd0, limit_reg}) : dt;
        span_bad = span[32] || (span == '0) || (span[31:0] < {22'd0, min_span_reg});
        hold_b   = span_bad || num_b[32];
        hold_e   = span_bad || dt_c[32] || (dt_c == '0);
        dy_raw   = $signed({{3{b_reg.yaw[31]}}, b_reg.yaw})
                 - $signed({{3{a_reg.yaw[31]}}, a_reg.yaw});
    end

    // one turn multiple per wrap step, largest first
    logic [2:0]         wrap_k;
    logic signed [34:0] turn, cand_sub, cand_add;
    logic [31:0]        mag_y, mag_p;
    logic [32:0]        r_y, r_p;
    logic               ge_y, ge_p;

    always_comb
    begin
        wrap_k   = 3'(WRAP_LAST[2:0] - cmd.step[2:0]);
        turn     = FULL_TURN <<< wrap_k;
        cand_sub = dy_reg - turn;
        cand_add = dy_reg + turn;
        mag_y    = dy_reg[34] ? 32'(-dy_reg) : dy_reg[31:0];
        mag_p    = dp_reg[32] ? 32'(-dp_reg) : dp_reg[31:0];
        r_y      = {rem_y_reg, prod_y_reg[63]};
        r_p      = {rem_p_reg, prod_p_reg[63]};
        ge_y     = (r_y >= {1'b0, den_reg});
        ge_p     = (r_p >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            tq_reg <= sample_time;
        end
        if (cmd.capture)
        begin
            a_reg <= b_reg;
            b_reg <= rdata;
        end
        if (cmd.setup)
        begin
            dy_reg       <= dy_raw;
            dp_reg       <= $signed({b_reg.pitch[31], b_reg.pitch})
                          - $signed({a_reg.pitch[31], a_reg.pitch});
            wrap_pos_reg <= (dy_raw > HALF_TURN);
            wrap_neg_reg <= (dy_raw < -HALF_TURN);
            hold_reg     <= (cmd.mode == MODE_BRACK) ? hold_b : hold_e;
            n_reg        <= (cmd.mode == MODE_BRACK) ? num_b[31:0] : dt_c[31:0];
            den_reg      <= span[31:0];
            prod_y_reg   <= '0;
            prod_p_reg   <= '0;
            rem_y_reg    <= '0;
            rem_p_reg    <= '0;
        end
        if (cmd.wrap_step)
        begin
            if (wrap_pos_reg && (cand_sub > -HALF_TURN))
            begin
                dy_reg <= cand_sub;
            end
            else if (wrap_neg_reg && (cand_add < HALF_TURN))
            begin
                dy_reg <= cand_add;
            end
        end
        if (cmd.mul_step)
        begin
            prod_y_reg <= {prod_y_reg[62:0], 1'b0} + (n_reg[31] ? {32'd0, mag_y} : 64'd0);
            prod_p_reg <= {prod_p_reg[62:0], 1'b0} + (n_reg[31] ? {32'd0, mag_p} : 64'd0);
            n_reg      <= {n_reg[30:0], 1'b0};
        end
        if (cmd.div_step)
        begin
            rem_y_reg  <= ge_y ? 32'(r_y - {1'b0, den_reg}) : r_y[31:0];
            rem_p_reg  <= ge_p ? 32'(r_p - {1'b0, den_reg}) : r_p[31:0];
            prod_y_reg <= {prod_y_reg[62:0], ge_y};
            prod_p_reg <= {prod_p_reg[62:0], ge_p};
        end
    end

    // final sums and saturation
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -67'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [66:0] ay, ap, dy67, dp67, qy, qp, res_y, res_p;

    always_comb
    begin
        ay   = 67'(a_reg.yaw);
        ap   = 67'(a_reg.pitch);
        dy67 = 67'(dy_reg);
        dp67 = 67'(dp_reg);
        qy   = dy_reg[34] ? -$signed({3'd0, prod_y_reg}) : $signed({3'd0, prod_y_reg});
        qp   = dp_reg[32] ? -$signed({3'd0, prod_p_reg}) : $signed({3'd0, prod_p_reg});
        unique case (cmd.mode)
            MODE_BRACK:
            begin
                res_y = hold_reg ? ay + dy67 : ay + qy;
                res_p = hold_reg ? ap + dp67 : ap + qp;
            end
            MODE_EXTRAP:
            begin
                res_y = hold_reg ? 67'(b_reg.yaw) : ay + dy67 + qy;
                res_p = hold_reg ? 67'(b_reg.pitch) : ap + dp67 + qp;
            end
            MODE_FIRST:
            begin
                res_y = 67'(b_reg.yaw);
                res_p = 67'(b_reg.pitch);
            end
            default:
            begin
                res_y = '0;
                res_p = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            valid_res <= (cmd.mode != MODE_EMPTY);
            yaw_out   <= sat32(res_y);
            pitch_out <= sat32(res_p);
        end
    end

endmodule

// File: rtl/core/pose_history_interpolator.sv
// ----------------------------------------------------------------------------
// pose_history_interpolator
// Timestamped turret pose ring with linear interpolation and extrapolation.
// ----------------------------------------------------------------------------
// in_ch carries one word per operation: push (append a sample, drop the
// oldest when 64 are held), query (pose at sample_time) or clear. Only a
// query returns a word on out_ch: valid_res, yaw_out, pitch_out.
// A query scans the ring from the oldest entry, one RAM read and one
// capture per entry scanned, as the ring has a single read port; then
// come a setup step, 8 yaw wrap steps, 32 multiply steps, 64 divide
// steps and a finish step into the output register. An empty ring, a
// ring of one sample, or a hit on the oldest sample, skips the
// arithmetic; a hold skips the multiply and divide.
// A new word is taken as soon as the sequencer is idle, also while a result
// waits in the output register; a query result holds until out_ch.ready.
// Reset empties the ring (no clearing pass) and loads the register defaults:
// extrapolation_limit_us 60000, min_span_us 1. cfg_we writes register
// cfg_index with cfg_data; user must write while the block is idle, unchecked.
// ----------------------------------------------------------------------------
module pose_history_interpolator import php_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    php_in_if.sink                in_ch,
    php_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    php_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.op),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    php_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .sample_time (in_ch.sample_time),
        .yaw_in      (in_ch.yaw_in),
        .pitch_in    (in_ch.pitch_in),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .valid_res   (out_ch.valid_res),
        .yaw_out     (out_ch.yaw_out),
        .pitch_out   (out_ch.pitch_out)
    );

endmodule
